// File: rtl/mpbpg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mpbpg_pkg
// Shared widths and types of the multi-port blink pattern generator.
// ----------------------------------------------------------------------------
package mpbpg_pkg;

  localparam int MAX_PORTS = 8;
  localparam int PORT_W    = 3;
  localparam int MS_W      = 16;
  localparam int TICKS_W   = 16;
  localparam int REPS_W    = 8;

  // item kinds
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_START = 1'b1;

  // per-channel update control for one item
  typedef struct packed {
    logic               tick;       // timer tick item is being applied
    logic               start;      // start item addressed to this channel
    logic               load;       // start item also loads a burst
    logic               level;      // first level of the start item
    logic [TICKS_W-1:0] on_ticks;
    logic [TICKS_W-1:0] off_ticks;
    logic [REPS_W-1:0]  reps;
  } chan_ctl_t;

endpackage
`default_nettype wire

// File: rtl/mpbpg_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mpbpg_in_if
// Item channel into the blink generator: valid/ready plus item fields.
// ----------------------------------------------------------------------------
interface mpbpg_in_if;
  import mpbpg_pkg::*;

  logic              valid;
  logic              ready;
  logic              kind;
  logic [PORT_W-1:0] port;
  logic              first_level;
  logic [MS_W-1:0]   on_ms;
  logic [MS_W-1:0]   off_ms;
  logic [REPS_W-1:0] repeat_count;

  modport source (
    output valid, kind, port, first_level, on_ms, off_ms, repeat_count,
    input  ready
  );
  modport sink (
    input  valid, kind, port, first_level, on_ms, off_ms, repeat_count,
    output ready
  );
endinterface
`default_nettype wire

// File: rtl/mpbpg_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mpbpg_out_if
// Result channel of the blink generator: valid/ready plus pin and run masks.
// ----------------------------------------------------------------------------
interface mpbpg_out_if;
  import mpbpg_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [MAX_PORTS-1:0] port_levels;
  logic [MAX_PORTS-1:0] active_ports;

  modport source (
    output valid, port_levels, active_ports,
    input  ready
  );
  modport sink (
    input  valid, port_levels, active_ports,
    output ready
  );
endinterface
`default_nettype wire

// File: rtl/mpbpg_ms2tick.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mpbpg_ms2tick
// Milliseconds to ticks: ms / TICK_MS, at least 1, via exact reciprocal.
// ----------------------------------------------------------------------------
module mpbpg_ms2tick #(
  parameter int TICK_MS = 10
) (
  input  wire logic [mpbpg_pkg::MS_W-1:0]    ms,
  output      logic [mpbpg_pkg::TICKS_W-1:0] ticks
);
  import mpbpg_pkg::*;

  // ceil(2^32 / TICK_MS); exact quotient for any 16-bit dividend
  localparam logic [63:0] RECIP64 =
    ((64'd1 << 32) + 64'(TICK_MS) - 64'd1) / 64'(TICK_MS);
  localparam logic [32:0] RECIP = RECIP64[32:0];
  localparam int PROD_W = MS_W + 33;

  logic [PROD_W-1:0] prod;

  assign prod  = PROD_W'(ms) * PROD_W'(RECIP);
  assign ticks = (ms >= MS_W'(TICK_MS)) ? prod[32 +: TICKS_W] : TICKS_W'(1);

endmodule
`default_nettype wire

// File: rtl/mpbpg_chan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mpbpg_chan
// One blink channel: pin level, burst counters and the enable flag.
// ----------------------------------------------------------------------------
module mpbpg_chan (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire mpbpg_pkg::chan_ctl_t ctl,
  output      logic                 pin,
  output      logic                 enabled
);
  import mpbpg_pkg::*;

  logic               pin_r, pin_nxt;
  logic               en_r, en_nxt;
  logic               lvl_r, lvl_nxt;
  logic [REPS_W-1:0]  blinks_r, blinks_nxt;
  logic [TICKS_W-1:0] on_rl_r, on_rl_nxt;
  logic [TICKS_W-1:0] off_rl_r, off_rl_nxt;
  logic [TICKS_W-1:0] on_cnt_r, on_cnt_nxt;
  logic [TICKS_W-1:0] off_cnt_r, off_cnt_nxt;

  always_comb begin
    pin_nxt     = pin_r;
    en_nxt      = en_r;
    lvl_nxt     = lvl_r;
    blinks_nxt  = blinks_r;
    on_rl_nxt   = on_rl_r;
    off_rl_nxt  = off_rl_r;
    on_cnt_nxt  = on_cnt_r;
    off_cnt_nxt = off_cnt_r;
    if (ctl.start) begin
      pin_nxt = ctl.level;
      if (ctl.load) begin
        en_nxt      = 1'b1;
        lvl_nxt     = ctl.level;
        blinks_nxt  = ctl.reps;
        on_rl_nxt   = ctl.on_ticks;
        off_rl_nxt  = ctl.off_ticks;
        on_cnt_nxt  = ctl.on_ticks;
        off_cnt_nxt = ctl.off_ticks;
      end
    end else if (ctl.tick && en_r) begin
      if (blinks_r != '0) begin
        if (on_cnt_r != '0) begin
          on_cnt_nxt = on_cnt_r - TICKS_W'(1);
          if (on_cnt_r == TICKS_W'(1)) begin
            pin_nxt = ~lvl_r;
          end
        end else if (off_cnt_r != '0) begin
          off_cnt_nxt = off_cnt_r - TICKS_W'(1);
        end else begin
          // one blink done: reload and go back to the first level if more remain
          blinks_nxt  = blinks_r - REPS_W'(1);
          if (blinks_r != REPS_W'(1)) begin
            pin_nxt = lvl_r;
          end
          on_cnt_nxt  = on_rl_r;
          off_cnt_nxt = off_rl_r;
        end
      end else begin
        pin_nxt = ~lvl_r;
        en_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pin_r <= 1'b0;
      en_r  <= 1'b0;
    end else begin
      pin_r <= pin_nxt;
      en_r  <= en_nxt;
    end
  end

  // burst payload is only read while the channel is enabled
  always_ff @(posedge clk) begin
    lvl_r     <= lvl_nxt;
    blinks_r  <= blinks_nxt;
    on_rl_r   <= on_rl_nxt;
    off_rl_r  <= off_rl_nxt;
    on_cnt_r  <= on_cnt_nxt;
    off_cnt_r <= off_cnt_nxt;
  end

  assign pin     = pin_r;
  assign enabled = en_r;

endmodule
`default_nettype wire

// File: rtl/multi_port_blink_pattern_generator.sv
`default_nettype none
// Result: offered once its item has passed the input register and been applied
//   to the channel state, which doubles as the result register.
// Throughput: one item per cycle; the input register and the channel state
//   advance together whenever the result slot is empty or being drained.
// Reset (synchronous, rst_n low): all pins low, all channels idle, no
//   pending item or result.
// ----------------------------------------------------------------------------
// multi_port_blink_pattern_generator
// Drives up to eight pins with blink bursts stepped by timer tick items.
// ----------------------------------------------------------------------------
module multi_port_blink_pattern_generator #(
  parameter int PORTS   = 8,
  parameter int TICK_MS = 10
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mpbpg_in_if.sink   in_ch,
  mpbpg_out_if.source out_ch
);
  import mpbpg_pkg::*;

  // --------------------------------------------------------------------------
  // Input register. Holds one item until the channels take it.
  // --------------------------------------------------------------------------
  logic              s1_valid_r;
  logic              s1_kind_r;
  logic [PORT_W-1:0] s1_port_r;
  logic              s1_level_r;
  logic [MS_W-1:0]   s1_on_ms_r;
  logic [MS_W-1:0]   s1_off_ms_r;
  logic [REPS_W-1:0] s1_reps_r;

  logic out_valid_r;
  logic advance;     // item in the input register is applied this cycle
  logic in_xfer;

  // The channel state doubles as the result register: it only moves when the
  // previous result has been taken, so the outputs read it directly.
  assign advance      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || advance;
  assign in_xfer      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_kind_r   <= in_ch.kind;
      s1_port_r   <= in_ch.port;
      s1_level_r  <= in_ch.first_level;
      s1_on_ms_r  <= in_ch.on_ms;
      s1_off_ms_r <= in_ch.off_ms;
      s1_reps_r   <= in_ch.repeat_count;
    end
  end

  // --------------------------------------------------------------------------
  // Time conversion: one constant-reciprocal multiply per phase length.
  // --------------------------------------------------------------------------
  logic [TICKS_W-1:0] on_ticks;
  logic [TICKS_W-1:0] off_ticks;

  mpbpg_ms2tick #(.TICK_MS(TICK_MS)) u_on_conv (
    .ms    (s1_on_ms_r),
    .ticks (on_ticks)
  );

  mpbpg_ms2tick #(.TICK_MS(TICK_MS)) u_off_conv (
    .ms    (s1_off_ms_r),
    .ticks (off_ticks)
  );

  // --------------------------------------------------------------------------
  // Decode. A start beyond the configured port count is dropped; a start with
  // zero on time or zero repeats only sets the pin level.
  // --------------------------------------------------------------------------
  logic do_tick;
  logic do_start;
  logic do_load;

  assign do_tick  = advance && (s1_kind_r == KIND_TICK);
  assign do_start = advance && (s1_kind_r == KIND_START) &&
                    ({1'b0, s1_port_r} < (PORT_W + 1)'(PORTS));
  assign do_load  = (s1_on_ms_r != '0) && (s1_reps_r != '0);

  // --------------------------------------------------------------------------
  // Channels. All enabled channels step in parallel on a tick.
  // --------------------------------------------------------------------------
  logic [MAX_PORTS-1:0] levels;
  logic [MAX_PORTS-1:0] actives;

  for (genvar g = 0; g < MAX_PORTS; g++) begin : g_chan
    if (g < PORTS) begin : g_used
      chan_ctl_t ctl;

      always_comb begin
        ctl.tick      = do_tick;
        ctl.start     = do_start && (s1_port_r == PORT_W'(g));
        ctl.load      = do_load;
        ctl.level     = s1_level_r;
        ctl.on_ticks  = on_ticks;
        ctl.off_ticks = off_ticks;
        ctl.reps      = s1_reps_r;
      end

      mpbpg_chan u_chan (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .pin     (levels[g]),
        .enabled (actives[g])
      );
    end else begin : g_unused
      // ports past the configured count read as zero
      assign levels[g]  = 1'b0;
      assign actives[g] = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Result channel.
  // --------------------------------------------------------------------------
  assign out_ch.valid        = out_valid_r;
  assign out_ch.port_levels  = levels;
  assign out_ch.active_ports = actives;

endmodule
`default_nettype wire

// File: bench/multi_port_blink_pattern_generator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_port_blink_pattern_generator_tb
// Self-checking bench for the blink generator. Tick and start commands are
// streamed into the item channel with random gaps and back-pressure on the
// result channel. A behavioral copy of the eight blink channels predicts the
// pin and run masks of every transfer, and each result is matched in order.
// ----------------------------------------------------------------------------
module multi_port_blink_pattern_generator_tb;
  import mpbpg_pkg::*;

  localparam int NUM_PORTS = 8;
  localparam int TICK_LEN  = 10;   // ms per tick

  typedef struct packed {
    logic              kind;
    logic [PORT_W-1:0] port;
    logic              first_level;
    logic [MS_W-1:0]   on_ms;
    logic [MS_W-1:0]   off_ms;
    logic [REPS_W-1:0] repeat_count;
  } blink_cmd_t;

  localparam int CMD_W = $bits(blink_cmd_t);

  typedef struct packed {
    logic [MAX_PORTS-1:0] port_levels;
    logic [MAX_PORTS-1:0] active_ports;
  } pin_masks_t;

  logic clk = 1'b0;
  logic rst_n;

  mpbpg_in_if  in_ch ();
  mpbpg_out_if out_ch ();

  multi_port_blink_pattern_generator #(
    .PORTS   (NUM_PORTS),
    .TICK_MS (TICK_LEN)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #6 clk = ~clk;

  // --------------------------------------------------------------------------
  // Behavioral copy of the channels. Updated once per input transfer.
  // --------------------------------------------------------------------------
  logic              pin_lvl    [NUM_PORTS];
  logic              burst_on   [NUM_PORTS];
  logic              first_lvl  [NUM_PORTS];
  logic [REPS_W-1:0] blinks_rem [NUM_PORTS];
  logic [TICKS_W-1:0] on_period  [NUM_PORTS];
  logic [TICKS_W-1:0] off_period [NUM_PORTS];
  logic [TICKS_W-1:0] on_left    [NUM_PORTS];
  logic [TICKS_W-1:0] off_left   [NUM_PORTS];

  pin_masks_t exp_masks_q[$];

  // bench knobs and bookkeeping
  bit tx_gaps;          // sender inserts idle cycles between transfers
  bit rx_random;        // receiver drops ready at random
  int rx_hold_left;     // long receiver hold-off, counted down by the receiver
  int rx_idle_left;
  int mismatches;
  int results_seen;
  int starts_sent;
  int ticks_sent;
  int bursts_done;

  function automatic void clear_channels();
    for (int p = 0; p < NUM_PORTS; p++) begin
      pin_lvl[p]    = 1'b0;
      burst_on[p]   = 1'b0;
      first_lvl[p]  = 1'b0;
      blinks_rem[p] = '0;
      on_period[p]  = '0;
      off_period[p] = '0;
      on_left[p]    = '0;
      off_left[p]   = '0;
    end
  endfunction

  // ms to ticks, never less than one tick
  function automatic logic [TICKS_W-1:0] ms_in_ticks(logic [MS_W-1:0] ms);
    if (ms >= TICK_LEN) return TICKS_W'(ms / TICK_LEN);
    return TICKS_W'(1);
  endfunction

  function automatic void step_channel(int p);
    if (!burst_on[p]) return;
    if (blinks_rem[p] != 0) begin
      if (on_left[p] != 0) begin
        on_left[p] = on_left[p] - 1'b1;
        if (on_left[p] == 0) pin_lvl[p] = ~first_lvl[p];
      end else if (off_left[p] != 0) begin
        off_left[p] = off_left[p] - 1'b1;
      end else begin
        // one blink used up; reload both phases
        blinks_rem[p] = blinks_rem[p] - 1'b1;
        if (blinks_rem[p] != 0) pin_lvl[p] = first_lvl[p];
        on_left[p]  = on_period[p];
        off_left[p] = off_period[p];
      end
    end else begin
      // burst over: pin stays inverted, channel goes idle
      pin_lvl[p]  = ~first_lvl[p];
      burst_on[p] = 1'b0;
      bursts_done++;
    end
  endfunction

  function automatic pin_masks_t predict_masks(blink_cmd_t c);
    pin_masks_t m;
    int         pn;
    pn = c.port;
    if (c.kind == KIND_TICK) begin
      for (int p = 0; p < NUM_PORTS; p++) step_channel(p);
    end else if (pn < NUM_PORTS) begin
      pin_lvl[pn] = c.first_level;
      // zero on time or zero repeats only sets the level
      if (c.on_ms != 0 && c.repeat_count != 0) begin
        burst_on[pn]   = 1'b1;
        blinks_rem[pn] = c.repeat_count;
        first_lvl[pn]  = c.first_level;
        on_period[pn]  = ms_in_ticks(c.on_ms);
        off_period[pn] = ms_in_ticks(c.off_ms);
        on_left[pn]    = on_period[pn];
        off_left[pn]   = off_period[pn];
      end
    end
    m = '0;
    for (int p = 0; p < NUM_PORTS; p++) begin
      m.port_levels[p]  = pin_lvl[p];
      m.active_ports[p] = burst_on[p];
    end
    return m;
  endfunction

  // --------------------------------------------------------------------------
  // Item builders
  // --------------------------------------------------------------------------
  function automatic blink_cmd_t start_cmd(int port, bit lvl, int on_ms, int off_ms,
                                           int reps);
    blink_cmd_t c;
    c.kind         = KIND_START;
    c.port         = PORT_W'(port);
    c.first_level  = lvl;
    c.on_ms        = MS_W'(on_ms);
    c.off_ms       = MS_W'(off_ms);
    c.repeat_count = REPS_W'(reps);
    return c;
  endfunction

  // tick with junk in the unused fields
  function automatic blink_cmd_t tick_cmd();
    blink_cmd_t c;
    c      = blink_cmd_t'(CMD_W'({$urandom, $urandom}));
    c.kind = KIND_TICK;
    return c;
  endfunction

  // start with short phases and a few blinks, so bursts run to the end
  function automatic blink_cmd_t short_burst_cmd();
    int on_ms;
    int reps;
    on_ms = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 45);
    reps  = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
    return start_cmd($urandom_range(0, NUM_PORTS - 1), 1'($urandom_range(0, 1)), on_ms,
                     $urandom_range(0, 45), reps);
  endfunction

  function automatic blink_cmd_t any_cmd();
    return blink_cmd_t'(CMD_W'({$urandom, $urandom}));
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  // --------------------------------------------------------------------------
  // Sender. Called at a rising edge, returns at a rising edge.
  // --------------------------------------------------------------------------
  task automatic send_cmd(blink_cmd_t c);
    int gap;
    in_ch.valid        <= 1'b1;
    in_ch.kind         <= c.kind;
    in_ch.port         <= c.port;
    in_ch.first_level  <= c.first_level;
    in_ch.on_ms        <= c.on_ms;
    in_ch.off_ms       <= c.off_ms;
    in_ch.repeat_count <= c.repeat_count;
    do @(posedge clk); while (!in_ch.ready);
    // transfer taken at this edge
    exp_masks_q.push_back(predict_masks(c));
    if (c.kind == KIND_TICK) ticks_sent++;
    else starts_sent++;
    gap = tx_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // sender goes quiet until every expected result has come back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (exp_masks_q.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: drives ready and checks every result transfer.
  // --------------------------------------------------------------------------
  task automatic check_masks();
    pin_masks_t exp;
    results_seen++;
    if (exp_masks_q.size() == 0) begin
      $error("unexpected result: port_levels %b active_ports %b",
             out_ch.port_levels, out_ch.active_ports);
      mismatches++;
      return;
    end
    exp = exp_masks_q.pop_front();
    if (out_ch.port_levels !== exp.port_levels) begin
      $error("port_levels: expected %b, actual %b", exp.port_levels, out_ch.port_levels);
      mismatches++;
    end
    if (out_ch.active_ports !== exp.active_ports) begin
      $error("active_ports: expected %b, actual %b", exp.active_ports, out_ch.active_ports);
      mismatches++;
    end
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) check_masks();
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_ch.ready <= 1'b0;
      end else if (rx_idle_left > 0) begin
        rx_idle_left--;
        out_ch.ready <= 1'b0;
      end else if (rx_random && $urandom_range(0, 99) >= 70) begin
        rx_idle_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 24)
                                                   : $urandom_range(0, 2);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Hand-picked cases, no idling on either side. Port numbers are 3 bits and
  // the build has eight ports, so no start can address a missing port.
  task automatic test_directed_cases();
    tx_gaps   = 1'b0;
    rx_random = 1'b0;
    send_cmd(tick_cmd());                                  // nothing enabled yet
    send_cmd(start_cmd(0, 1'b1, 0, 50, 3));                // zero on time: level only
    send_cmd(start_cmd(1, 1'b1, 50, 50, 0));               // zero repeats: level only
    send_cmd(start_cmd(7, 1'b1, 9, 0, 1));                 // under one tick, zero off
    send_cmd(start_cmd(3, 1'b0, 65535, 65535, 255));       // largest burst
    send_cmd(start_cmd(2, 1'b0, 20, 10, 2));
    repeat (6) send_cmd(tick_cmd());                       // port 7 runs out
    send_cmd(start_cmd(2, 1'b1, 10, 10, 1));               // restart a running burst
    send_cmd(start_cmd(3, 1'b1, 0, 0, 0));                 // level only, burst keeps going
    repeat (8) send_cmd(tick_cmd());
    send_cmd(start_cmd(6, 1'b1, 19, 20, 1));
    send_cmd(start_cmd(5, 1'b0, 65535, 0, 255));
    send_cmd(tick_cmd());
  endtask

  // Well-formed bursts on random ports, mostly ticks so they play out fully.
  task automatic test_short_bursts(int n);
    tx_gaps   = 1'b1;
    rx_random = 1'b1;
    repeat (n) begin
      if ($urandom_range(0, 99) < 25) send_cmd(short_burst_cmd());
      else send_cmd(tick_cmd());
    end
  endtask

  // Receiver holds off for a long stretch while items keep coming; the
  // block has to fill up and push back on the input.
  task automatic test_backpressure(int n);
    tx_gaps      = 1'b0;
    rx_hold_left = 80;
    repeat (n) begin
      if ($urandom_range(0, 3) == 0) send_cmd(short_burst_cmd());
      else send_cmd(tick_cmd());
    end
    tx_gaps = 1'b1;
  endtask

  // Sender stops and lets the pipeline empty before going on.
  task automatic test_drain_pause(int n);
    repeat (2) begin
      repeat (n) begin
        if ($urandom_range(0, 3) == 0) send_cmd(short_burst_cmd());
        else send_cmd(tick_cmd());
      end
      wait_drained();
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // Any field value at all, long phases and big repeat counts included.
  task automatic test_random_fields(int n);
    repeat (n) send_cmd(any_cmd());
  endtask

  task automatic finish_run();
    int waited;
    waited = 0;
    in_ch.valid <= 1'b0;
    while (exp_masks_q.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (6) @(posedge clk);
    if (exp_masks_q.size() != 0) begin
      $error("%0d expected results never arrived", exp_masks_q.size());
      mismatches++;
    end
    $display("Sent %0d starts and %0d ticks, checked %0d results.",
             starts_sent, ticks_sent, results_seen);
    $display("%0d bursts ran to completion, with receiver stalls and sender gaps.",
             bursts_done);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  endtask

  initial begin
    tx_gaps      = 1'b0;
    rx_random    = 1'b0;
    rx_hold_left = 0;
    rx_idle_left = 0;
    mismatches   = 0;
    results_seen = 0;
    starts_sent  = 0;
    ticks_sent   = 0;
    bursts_done  = 0;
    clear_channels();
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.kind         <= KIND_TICK;
    in_ch.port         <= '0;
    in_ch.first_level  <= 1'b0;
    in_ch.on_ms        <= '0;
    in_ch.off_ms       <= '0;
    in_ch.repeat_count <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_short_bursts(400);
    test_backpressure(40);
    test_drain_pause(40);
    test_random_fields(205);
    finish_run();
  end

  // run limit, far above the slowest legal run
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: files.f
rtl/mpbpg_pkg.sv
rtl/mpbpg_in_if.sv
rtl/mpbpg_out_if.sv
rtl/mpbpg_ms2tick.sv
rtl/mpbpg_chan.sv
rtl/multi_port_blink_pattern_generator.sv
bench/multi_port_blink_pattern_generator_tb.sv
